// ===== hdl/rgbconv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbconv_pkg
// Shared types, register indexes and kernel arithmetic for the 3x3 RGB filter.
// ----------------------------------------------------------------------------
package rgbconv_pkg;

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 11;

  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_KERNEL_MODE  = 2'd2;

  localparam int FRAME_WIDTH_RESET  = 640;
  localparam int FRAME_HEIGHT_RESET = 480;
  localparam int MAX_HEIGHT         = 1024;

  localparam logic MODE_BLUR    = 1'b0;
  localparam logic MODE_SHARPEN = 1'b1;

  localparam int WIN_COLS = 3;

  // one rgb pixel, red in the top byte
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // one window column, top row first
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // column sums of one channel
  typedef struct packed {
    logic [9:0] plain;     // top + mid + bot
    logic [9:0] weighted;  // top + 2*mid + bot
  } chsum_t;

  typedef struct packed {
    chsum_t red;
    chsum_t green;
    chsum_t blue;
  } col_sum_t;

  // kernel sums before scaling, two's complement
  typedef struct packed {
    logic [12:0] red;
    logic [12:0] green;
    logic [12:0] blue;
  } raw_t;

  typedef struct packed {
    logic main_px;   // result for the pixel up and to the left
    logic filt_px;   // that pixel is an interior pixel
    logic last_col;  // extra border result at the end of the row above
    logic last_row;  // extra border result for the current pixel
  } flags_t;

  typedef struct packed {
    logic [9:0] row_up;
    logic [9:0] row_cur;
    logic [9:0] col_left;
    logic [9:0] col_cur;
    flags_t     flags;
  } tag_t;

  // combine three column sums of one channel
  function automatic logic [12:0] conv_raw(chsum_t a, chsum_t b, chsum_t c,
                                           logic [7:0] m, logic mode);
    logic [12:0] blur;
    logic [12:0] s_all;
    logic [12:0] ten_m;
    blur  = 13'(a.weighted) + (13'(b.weighted) << 1) + 13'(c.weighted);
    s_all = 13'(a.plain) + 13'(b.plain) + 13'(c.plain);
    ten_m = (13'(m) << 3) + (13'(m) << 1);
    return (mode == MODE_SHARPEN) ? (ten_m - s_all) : blur;
  endfunction

  // divide by 16 for blur, clamp to 0..255 for sharpen
  function automatic logic [7:0] px_final(logic [12:0] raw, logic mode);
    logic [7:0] res;
    if (mode == MODE_SHARPEN) begin
      if (raw[12]) res = 8'd0;
      else if (raw[11:8] != 4'd0) res = 8'hff;
      else res = raw[7:0];
    end else begin
      res = raw[11:4];
    end
    return res;
  endfunction

endpackage

// ===== hdl/rgbconv_ram.sv =====
// ----------------------------------------------------------------------------
// rgbconv_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rgbconv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/rgbconv_cell.sv =====
// ----------------------------------------------------------------------------
// rgbconv_cell
// One column of the 3x3 window; passes its column on to the next cell.
// ----------------------------------------------------------------------------
module rgbconv_cell import rgbconv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     shift_en,
  input  col_t     col_in,
  output col_t     col_out,
  output col_sum_t sum_out
);

  col_t col_r;

  function automatic chsum_t ch_sum(logic [7:0] t, logic [7:0] m, logic [7:0] b);
    chsum_t s;
    s.plain    = 10'(t) + 10'(m) + 10'(b);
    s.weighted = 10'(t) + (10'(m) << 1) + 10'(b);
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out       = col_r;
  assign sum_out.red   = ch_sum(col_r.top.red,   col_r.mid.red,   col_r.bot.red);
  assign sum_out.green = ch_sum(col_r.top.green, col_r.mid.green, col_r.bot.green);
  assign sum_out.blue  = ch_sum(col_r.top.blue,  col_r.mid.blue,  col_r.bot.blue);

endmodule

// ===== hdl/rgb_3x3_blur_or_sharpen_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_3x3_blur_or_sharpen_unit
// Streaming 3x3 blur or sharpen filter over raster-order RGB pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one word per clock while in_ready is high.
// Each channel is filtered with a 1-2-1 gaussian (sum / 16) or a sharpen
// (center 9, neighbors -1, clamped to 0..255); first/last row and column
// pixels come out as zero. Every result carries its row and column, and
// results are not in strict raster order. An input pixel causes 0 to 3 result
// words and the output port delivers one word per clock while out_ready is
// high, so the block takes one pixel per clock while each pixel gives at most
// one result; the last pixel of a row, and pixels of the last row, hold the
// input until their extra result words are taken. Two line buffer RAMs (one
// read, one write per clock) hold the two rows above; a chain of three column
// cells holds the window. Geometry writes restart the frame at row 0, column
// 0; config must be written only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module rgb_3x3_blur_or_sharpen_unit import rgbconv_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  // pixel input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_red_in,
  input  logic [7:0]        in_green_in,
  input  logic [7:0]        in_blue_in,
  // result output
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_red_out,
  output logic [7:0]        out_green_out,
  output logic [7:0]        out_blue_out,
  output logic [9:0]        out_row,
  output logic [9:0]        out_col,
  output logic              out_last_of_run,
  // configuration
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int W_RST = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;
  localparam logic [CW-1:0] W_LAST_RST = CW'(W_RST - 1);
  localparam logic [9:0]    H_LAST_RST = 10'(FRAME_HEIGHT_RESET - 1);

  // ---------------------------------------------------------------- config
  // geometry is kept as last column / last row index, already saturated
  logic [CW-1:0] w_last_r, w_last_nxt;
  logic [9:0]    h_last_r, h_last_nxt;
  logic          mode_r;
  logic          geom_wr;

  always_comb begin
    if (cfg_wdata == '0) begin
      w_last_nxt = '0;
    end else if (32'(cfg_wdata) > MAX_WIDTH) begin
      w_last_nxt = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_nxt = CW'(32'(cfg_wdata) - 32'd1);
    end
    if (cfg_wdata == '0) begin
      h_last_nxt = '0;
    end else if (32'(cfg_wdata) > MAX_HEIGHT) begin
      h_last_nxt = 10'(MAX_HEIGHT - 1);
    end else begin
      h_last_nxt = 10'(32'(cfg_wdata) - 32'd1);
    end
  end

  assign geom_wr = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= W_LAST_RST;
      h_last_r <= H_LAST_RST;
      mode_r   <= MODE_BLUR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  w_last_r <= w_last_nxt;
        REG_FRAME_HEIGHT: h_last_r <= h_last_nxt;
        REG_KERNEL_MODE:  mode_r   <= cfg_wdata[0];
        default:          ;  // unused index, ignored
      endcase
    end
  end

  // ------------------------------------------------------------ handshake
  logic in_acc;
  logic en;       // whole pipeline advances by one stage

  assign in_ready = en;
  assign in_acc   = in_valid && en;

  // ------------------------------------------------------- raster position
  logic [9:0]    row_pos_r, row_pos_nxt;
  logic [CW-1:0] col_pos_r, col_pos_nxt;

  always_comb begin
    if (col_pos_r == w_last_r) begin
      col_pos_nxt = '0;
      row_pos_nxt = (row_pos_r == h_last_r) ? 10'd0 : row_pos_r + 10'd1;
    end else begin
      col_pos_nxt = col_pos_r + CW'(1);
      row_pos_nxt = row_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
    end else if (geom_wr) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
    end else if (in_acc) begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
    end
  end

  // result schedule of the incoming word, settled at accept time
  tag_t tag_in;

  always_comb begin
    tag_in.row_up         = row_pos_r - 10'd1;
    tag_in.row_cur        = row_pos_r;
    tag_in.col_left       = 10'(col_pos_r - CW'(1));
    tag_in.col_cur        = 10'(col_pos_r);
    tag_in.flags.main_px  = (row_pos_r != '0) && (col_pos_r != '0);
    tag_in.flags.filt_px  = (row_pos_r > 10'd1) && (col_pos_r > CW'(1));
    tag_in.flags.last_col = (row_pos_r != '0) && (col_pos_r == w_last_r);
    tag_in.flags.last_row = (row_pos_r == h_last_r);
  end

  // --------------------------------------------------------- pipeline
  // s0: input word, line buffer read data
  // s1: window cells loaded, column sums
  // s2: kernel sums
  logic          v0_r, v1_r, v2_r;
  tag_t          tag0_r, tag1_r, tag2_r;
  pix_t          px0_r;
  logic [CW-1:0] c0_r;
  raw_t          raw2_r, raw_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag0_r <= tag_in;
      px0_r  <= {in_red_in, in_green_in, in_blue_in};
      c0_r   <= col_pos_r;
      tag1_r <= tag0_r;
      tag2_r <= tag1_r;
      raw2_r <= raw_nxt;
    end
  end

  // ------------------------------------------------------ line buffers
  // read on accept at the new column, write back when the word leaves s0
  logic lb_we;
  pix_t mid_px, top_px;

  assign lb_we = en && v0_r;

  rgbconv_ram #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_above (
    .clk   (clk),
    .we    (lb_we),
    .waddr (c0_r),
    .wdata (px0_r),
    .re    (in_acc),
    .raddr (col_pos_r),
    .rdata (mid_px)
  );

  rgbconv_ram #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_two_above (
    .clk   (clk),
    .we    (lb_we),
    .waddr (c0_r),
    .wdata (mid_px),
    .re    (in_acc),
    .raddr (col_pos_r),
    .rdata (top_px)
  );

  // ------------------------------------------------------- window cells
  // cell 2 takes the new column, cell 0 holds the oldest one
  col_t     new_col;
  col_t     cell_in [WIN_COLS];
  col_t     col_q   [WIN_COLS];
  col_sum_t sum_q   [WIN_COLS];

  assign new_col.top = top_px;
  assign new_col.mid = mid_px;
  assign new_col.bot = px0_r;

  for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
    if (k == WIN_COLS - 1) begin : g_head
      assign cell_in[k] = new_col;
    end else begin : g_link
      assign cell_in[k] = col_q[k+1];
    end

    rgbconv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (lb_we),
      .col_in   (cell_in[k]),
      .col_out  (col_q[k]),
      .sum_out  (sum_q[k])
    );
  end

  // kernel sums from the three column sums and the center pixel
  assign raw_nxt.red   = conv_raw(sum_q[0].red,   sum_q[1].red,   sum_q[2].red,
                                  col_q[1].mid.red, mode_r);
  assign raw_nxt.green = conv_raw(sum_q[0].green, sum_q[1].green, sum_q[2].green,
                                  col_q[1].mid.green, mode_r);
  assign raw_nxt.blue  = conv_raw(sum_q[0].blue,  sum_q[1].blue,  sum_q[2].blue,
                                  col_q[1].mid.blue, mode_r);

  // ------------------------------------------------------ output register
  // mask bit 0: up-left pixel, bit 1: row-end border, bit 2: last-row border
  logic [2:0] em_mask_r, em_mask_nxt, mask_clr;
  tag_t       em_tag_r;
  pix_t       em_pix_r, em_pix_nxt;

  always_comb begin
    mask_clr = em_mask_r & (em_mask_r - 3'd1);
    en       = (em_mask_r == '0) || ((mask_clr == '0) && out_ready);
    if (en) begin
      em_mask_nxt = {tag2_r.flags.last_row, tag2_r.flags.last_col,
                     tag2_r.flags.main_px} & {3{v2_r}};
    end else if (out_ready) begin
      em_mask_nxt = mask_clr;
    end else begin
      em_mask_nxt = em_mask_r;
    end
    if (tag2_r.flags.filt_px) begin
      em_pix_nxt.red   = px_final(raw2_r.red,   mode_r);
      em_pix_nxt.green = px_final(raw2_r.green, mode_r);
      em_pix_nxt.blue  = px_final(raw2_r.blue,  mode_r);
    end else begin
      em_pix_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_mask_r <= '0;
    end else begin
      em_mask_r <= em_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      em_tag_r <= tag2_r;
      em_pix_r <= em_pix_nxt;
    end
  end

  // pending results go out lowest mask bit first
  always_comb begin
    out_valid       = (em_mask_r != '0);
    out_last_of_run = (mask_clr == '0);
    if (em_mask_r[0]) begin
      out_row       = em_tag_r.row_up;
      out_col       = em_tag_r.col_left;
      out_red_out   = em_pix_r.red;
      out_green_out = em_pix_r.green;
      out_blue_out  = em_pix_r.blue;
    end else if (em_mask_r[1]) begin
      out_row       = em_tag_r.row_up;
      out_col       = em_tag_r.col_cur;
      out_red_out   = '0;
      out_green_out = '0;
      out_blue_out  = '0;
    end else begin
      out_row       = em_tag_r.row_cur;
      out_col       = em_tag_r.col_cur;
      out_red_out   = '0;
      out_green_out = '0;
      out_blue_out  = '0;
    end
  end

  // ------------------------------------------------------- assertions
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_pos_r <= w_last_r) && (row_pos_r <= h_last_r))
    else $error("raster position outside frame");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_run) |=> out_valid)
    else $error("result run cut short");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  a_filt_main: assert property (@(posedge clk) disable iff (!rst_n)
    ((em_mask_r != '0) && em_tag_r.flags.filt_px) |-> em_tag_r.flags.main_px)
    else $error("interior pixel without its result slot");

endmodule
